FILE: rtl/core/sliding_slope_estimator_corrector_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sliding slope estimator and corrector.
// Each macro expects clk_i and rst_ni to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef SLIDING_SLOPE_ESTIMATOR_CORRECTOR_UNIT_ASSERT_SVH
`define SLIDING_SLOPE_ESTIMATOR_CORRECTOR_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SSE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/sse_pkg.sv
// ----------------------------------------------------------------------------
// sse_pkg
// Shared types and constants of the sliding slope estimator and corrector.
// ----------------------------------------------------------------------------
package sse_pkg;

  // Default window length of the delay line.
  localparam int unsigned WINDOW_SIZE_DEF = 29;

  // Depth of the request queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Field and register widths.
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned GAIN_W   = 24;
  localparam int unsigned THR_W    = 16;
  localparam int unsigned WSUM_W   = 24;
  localparam int unsigned Q_W      = 32;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;

  // Shared multiplier: 32-bit signed operand times a 25-bit signed gain.
  localparam int unsigned MUL_B_W  = GAIN_W + 1;
  localparam int unsigned MUL_P_W  = Q_W + MUL_B_W;

  // Register values after reset.
  localparam logic [GAIN_W-1:0] SLOPE_GAIN_RST = 24'd14580;
  localparam logic [GAIN_W-1:0] GAIN_K_RST     = 24'd65536;
  localparam logic [GAIN_W-1:0] STEP_RATIO_RST = 24'd20480;
  localparam logic [GAIN_W-1:0] GAIN_G_RST     = 24'd655360;
  localparam logic [THR_W-1:0]  FLUSH_THR_RST  = 16'd1;

  // Register index, taken from the word address.
  typedef enum logic [2:0] {
    REG_SLOPE_GAIN = 3'd0,
    REG_GAIN_K     = 3'd1,
    REG_STEP_RATIO = 3'd2,
    REG_GAIN_G     = 3'd3,
    REG_FLUSH_THR  = 3'd4
  } sse_reg_e;

  // Configuration seen by the back.
  typedef struct packed {
    logic [GAIN_W-1:0] slope_gain;
    logic [GAIN_W-1:0] gain_k;
    logic [GAIN_W-1:0] step_ratio;
    logic [GAIN_W-1:0] gain_g;
    logic [THR_W-1:0]  flush_threshold;
  } sse_cfg_t;

  // Head of the request queue.
  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] sample;
  } sse_head_t;

  // Back sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_MUL_RATE,
    ST_SAT_RATE,
    ST_MUL_K,
    ST_ERR,
    ST_MUL_STEP,
    ST_INTEG,
    ST_MUL_G,
    ST_CORR
  } sse_state_e;

  // Operand selection of the shared multiplier.
  typedef enum logic [1:0] {
    MS_SUM,
    MS_RATE,
    MS_STEP,
    MS_GAIN_G
  } sse_mul_sel_e;

  // Control decoded from the back sequencer state.
  typedef struct packed {
    logic         pop;
    logic         sum_init;
    logic         sum_run;
    logic         mul_en;
    sse_mul_sel_e mul_sel;
    logic         ld_flush;
    logic         mem_we;
    logic         ld_rate;
    logic         ld_err;
    logic         ld_integ;
    logic         ld_out;
  } sse_ctl_t;

endpackage

FILE: rtl/core/sse_front.sv
// ----------------------------------------------------------------------------
// sse_front
// Accepts samples and holds them in a short queue until the back takes them.
// ----------------------------------------------------------------------------
module sse_front
  import sse_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output sse_head_t                  head_o,
  input  logic                       pop_i
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic signed [SAMPLE_W-1:0] slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]           wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]           rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic                       push;
  logic                       pop;

  // A request is taken whenever a slot is free.
  assign in_ready_o = (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (cnt_q != '0);

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= sample_i;
    end
  end

  // Oldest waiting request.
  assign head_o.valid  = (cnt_q != '0);
  assign head_o.sample = slot_q[rd_ptr_q];

endmodule

FILE: rtl/core/sse_back.sv
// ----------------------------------------------------------------------------
// sse_back
// Window sum over a circular sample memory, then the slope scaling and the
// proportional-plus-integral corrector on one shared multiplier.
// ----------------------------------------------------------------------------
module sse_back
  import sse_pkg::*;
#(
  parameter int unsigned WindowSize = WINDOW_SIZE_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sse_cfg_t                 cfg_i,
  input  sse_head_t                head_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [WSUM_W-1:0] window_sum_o,
  output logic signed [Q_W-1:0]    rate_o,
  output logic signed [Q_W-1:0]    corrected_o
);

  localparam int unsigned AW     = $clog2(WindowSize);
  localparam int unsigned K_LAST = (WindowSize - 1) / 2;
  localparam int unsigned KW     = $clog2(K_LAST + 2);
  localparam int unsigned WGT_W  = $clog2(WindowSize + 1);
  localparam int unsigned PROD_W = SAMPLE_W + WGT_W + 1;
  localparam int unsigned SUM_W  = SAMPLE_W + 1 + $clog2(WindowSize * WindowSize);
  localparam int unsigned RND_W  = MUL_P_W - 16;
  localparam int unsigned ADD_W  = RND_W + 1;

  localparam logic signed [MUL_P_W-1:0] MAX32   = 57'sd2147483647;
  localparam logic signed [MUL_P_W-1:0] MIN32   = -57'sd2147483648;
  localparam logic signed [MUL_P_W-1:0] HALF_LSB = 57'sd32768;
  localparam logic signed [Q_W-1:0]     MAX24   = 32'sd8388607;
  localparam logic signed [Q_W-1:0]     MIN24   = -32'sd8388608;

  // Saturate a wide value to the signed 32-bit range.
  function automatic logic signed [Q_W-1:0] sat32(input logic signed [MUL_P_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if (v > MAX32) begin
      r = MAX32[Q_W-1:0];
    end else if (v < MIN32) begin
      r = MIN32[Q_W-1:0];
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

  // Saturate to the signed 24-bit range of the window sum field.
  function automatic logic signed [WSUM_W-1:0] sat24(input logic signed [Q_W-1:0] v);
    logic signed [WSUM_W-1:0] r;
    if (v > MAX24) begin
      r = MAX24[WSUM_W-1:0];
    end else if (v < MIN24) begin
      r = MIN24[WSUM_W-1:0];
    end else begin
      r = v[WSUM_W-1:0];
    end
    return r;
  endfunction

  sse_state_e state_q, state_d;
  sse_ctl_t   ctl;

  // Sample memory, its valid bits and the write position.
  logic signed [SAMPLE_W-1:0] mem [WindowSize];
  logic [WindowSize-1:0]      valid_q;
  logic [AW-1:0]              wp_q;

  // Window sum pipeline.
  logic signed [SAMPLE_W-1:0] x_q;
  logic [KW-1:0]              k_q;
  logic [AW-1:0]              addr_a_q, addr_b_q;
  logic                       issue;
  logic signed [SAMPLE_W-1:0] ra_q, rb_q;
  logic                       ra_ok_q, rb_ok_q, a_is_x_q;
  logic [WGT_W-1:0]           wgt_q;
  logic                       rd_vld_q;
  logic signed [SAMPLE_W-1:0] a_val, b_val;
  logic signed [SAMPLE_W:0]   diff_wide;
  logic signed [SAMPLE_W-1:0] diff;
  logic signed [PROD_W-1:0]   prod_d, prod_q;
  logic                       prod_vld_q;
  logic signed [SUM_W-1:0]    acc_q;
  logic signed [Q_W-1:0]      acc_ext;

  // Corrector datapath.
  logic signed [Q_W-1:0]      mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [MUL_P_W-1:0]  mul_q;
  logic signed [MUL_P_W-1:0]  rnd_sum;
  logic signed [RND_W-1:0]    rnd_val;
  logic signed [ADD_W-1:0]    err_wide, integ_wide, corr_wide;
  logic [Q_W:0]               integ_mag;
  logic signed [Q_W-1:0]      w_q, rate_q, e_q, integ_q;

  // Output register.
  logic                       out_vld_q;
  logic                       out_free;
  logic signed [WSUM_W-1:0]   out_wsum_q;
  logic signed [Q_W-1:0]      out_rate_q, out_corr_q;

  assign out_free = !out_vld_q || out_ready_i;
  assign issue    = ctl.sum_run && (k_q <= KW'(K_LAST));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (head_i.valid) state_d = ST_SUM;
      ST_SUM:      if (!issue && !rd_vld_q) state_d = ST_MUL_RATE;
      ST_MUL_RATE: state_d = ST_SAT_RATE;
      ST_SAT_RATE: state_d = ST_MUL_K;
      ST_MUL_K:    state_d = ST_ERR;
      ST_ERR:      state_d = ST_MUL_STEP;
      ST_MUL_STEP: state_d = ST_INTEG;
      ST_INTEG:    state_d = ST_MUL_G;
      ST_MUL_G:    state_d = ST_CORR;
      ST_CORR:     if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    ctl = '0;
    ctl.mul_sel = MS_SUM;
    unique case (state_q)
      ST_IDLE: begin
        ctl.pop      = head_i.valid;
        ctl.sum_init = head_i.valid;
      end
      ST_SUM: begin
        ctl.sum_run = 1'b1;
      end
      ST_MUL_RATE: begin
        ctl.mul_en   = 1'b1;
        ctl.mul_sel  = MS_SUM;
        ctl.ld_flush = 1'b1;
        ctl.mem_we   = 1'b1;
      end
      ST_SAT_RATE: begin
        ctl.ld_rate = 1'b1;
      end
      ST_MUL_K: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MS_RATE;
      end
      ST_ERR: begin
        ctl.ld_err = 1'b1;
      end
      ST_MUL_STEP: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MS_STEP;
      end
      ST_INTEG: begin
        ctl.ld_integ = 1'b1;
      end
      ST_MUL_G: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MS_GAIN_G;
      end
      ST_CORR: begin
        ctl.ld_out = out_free;
      end
      default: ctl = '0;
    endcase
  end

  assign pop_o = ctl.pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sample memory: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (ctl.mem_we) begin
      mem[wp_q] <= x_q;
    end
    if (issue) begin
      ra_q <= mem[addr_a_q];
      rb_q <= mem[addr_b_q];
    end
  end

  // Valid bits stand in for the cleared delay line; the write position
  // steps round the memory once per sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      wp_q    <= '0;
    end else if (ctl.mem_we) begin
      valid_q[wp_q] <= 1'b1;
      wp_q          <= (wp_q == AW'(WindowSize - 1)) ? '0 : wp_q + 1'b1;
    end
  end

  // Read addresses walk outwards from the write position: one back in time,
  // the other towards the oldest sample, so each pair shares one weight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q        <= '0;
      addr_a_q   <= '0;
      addr_b_q   <= '0;
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      rd_vld_q   <= issue;
      prod_vld_q <= rd_vld_q;
      if (ctl.sum_init) begin
        k_q      <= '0;
        addr_a_q <= wp_q;
        addr_b_q <= wp_q;
      end else if (issue) begin
        k_q      <= k_q + 1'b1;
        addr_a_q <= (addr_a_q == '0) ? AW'(WindowSize - 1) : addr_a_q - 1'b1;
        addr_b_q <= (addr_b_q == AW'(WindowSize - 1)) ? '0 : addr_b_q + 1'b1;
      end
    end
  end

  // Per-term side information travels with the read data.
  always_ff @(posedge clk_i) begin
    if (ctl.sum_init) begin
      x_q <= head_i.sample;
    end
    if (issue) begin
      a_is_x_q <= (k_q == '0);
      ra_ok_q  <= valid_q[addr_a_q];
      rb_ok_q  <= valid_q[addr_b_q];
      wgt_q    <= WGT_W'(WindowSize - 2 * int'(k_q));
    end
  end

  // Pairwise difference wraps to 16 bits, then takes its weight.
  always_comb begin
    a_val     = a_is_x_q ? x_q : (ra_ok_q ? ra_q : '0);
    b_val     = rb_ok_q ? rb_q : '0;
    diff_wide = {a_val[SAMPLE_W-1], a_val} - {b_val[SAMPLE_W-1], b_val};
    diff      = diff_wide[SAMPLE_W-1:0];
    prod_d    = diff * $signed({1'b0, wgt_q});
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      prod_q <= prod_d;
    end
    if (ctl.sum_init) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + SUM_W'(prod_q);
    end
  end

  assign acc_ext = Q_W'(acc_q);

  // Shared multiplier operands.
  always_comb begin
    unique case (ctl.mul_sel)
      MS_SUM: begin
        mul_a = acc_ext;
        mul_b = $signed({1'b0, cfg_i.slope_gain});
      end
      MS_RATE: begin
        mul_a = rate_q;
        mul_b = $signed({1'b0, cfg_i.gain_k});
      end
      MS_STEP: begin
        mul_a = e_q;
        mul_b = $signed({1'b0, cfg_i.step_ratio});
      end
      MS_GAIN_G: begin
        mul_a = e_q;
        mul_b = $signed({1'b0, cfg_i.gain_g});
      end
      default: begin
        mul_a = acc_ext;
        mul_b = $signed({1'b0, cfg_i.slope_gain});
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl.mul_en) begin
      mul_q <= mul_a * mul_b;
    end
  end

  // Round the Q25.32 product to Q16.16, ties towards plus infinity.
  always_comb begin
    rnd_sum    = mul_q + HALF_LSB;
    rnd_val    = rnd_sum[MUL_P_W-1:16];
    err_wide   = ADD_W'(rnd_val) - ADD_W'(w_q);
    integ_wide = ADD_W'(rnd_val) + ADD_W'(w_q);
    corr_wide  = ADD_W'(rnd_val) + ADD_W'(integ_q);
    integ_mag  = integ_q[Q_W-1] ? ((Q_W + 1)'(0) - {1'b1, integ_q}) : {1'b0, integ_q};
  end

  // Corrector registers; the integrator is state and resets to zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else if (ctl.ld_integ) begin
      integ_q <= sat32(MUL_P_W'(integ_wide));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.ld_flush) begin
      w_q <= (integ_mag < (Q_W + 1)'(cfg_i.flush_threshold)) ? '0 : integ_q;
    end
    if (ctl.ld_rate) begin
      rate_q <= sat32(mul_q);
    end
    if (ctl.ld_err) begin
      e_q <= sat32(MUL_P_W'(err_wide));
    end
    if (ctl.ld_integ) begin
      w_q <= sat32(MUL_P_W'(integ_wide));
    end
  end

  // Result register, held until the consumer takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ctl.ld_out) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.ld_out) begin
      out_wsum_q <= sat24(acc_ext);
      out_rate_q <= rate_q;
      out_corr_q <= sat32(MUL_P_W'(corr_wide));
    end
  end

  assign out_valid_o  = out_vld_q;
  assign window_sum_o = out_wsum_q;
  assign rate_o       = out_rate_q;
  assign corrected_o  = out_corr_q;

endmodule

FILE: rtl/core/sliding_slope_estimator_corrector_unit.sv
// ----------------------------------------------------------------------------
// sliding_slope_estimator_corrector_unit
// Sliding least-squares slope estimate of wrapping angle codes, followed by a
// proportional-plus-integral corrector with a flushed integrator.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake              Payload
//   input     in_valid_i/in_ready_o  sample_i
//   output    out_valid_o/out_ready_i window_sum_o, rate_o, corrected_o
//   config    psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
// Each sample passes through the back in order: the pairwise window sum,
// one pair per cycle through the two memory read ports, then eight steps
// of the corrector sequence around the shared multiplier.
// After reset the delay line reads as zero through per-entry valid bits, so
// no clearing pass is needed. A two-entry queue keeps taking samples while a
// result waits at the output.
// ----------------------------------------------------------------------------
module sliding_slope_estimator_corrector_unit
  import sse_pkg::*;
#(
  parameter int unsigned WindowSize = WINDOW_SIZE_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [WSUM_W-1:0] window_sum_o,
  output logic signed [Q_W-1:0]    rate_o,
  output logic signed [Q_W-1:0]    corrected_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  sse_cfg_t  cfg_q;
  sse_head_t head;
  logic      pop;
  logic      cfg_we;
  sse_reg_e  reg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = sse_reg_e'(paddr[ADDR_W-1:2]);

  // Configuration registers; bits above each width are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slope_gain      <= SLOPE_GAIN_RST;
      cfg_q.gain_k          <= GAIN_K_RST;
      cfg_q.step_ratio      <= STEP_RATIO_RST;
      cfg_q.gain_g          <= GAIN_G_RST;
      cfg_q.flush_threshold <= FLUSH_THR_RST;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_SLOPE_GAIN: cfg_q.slope_gain      <= pwdata[GAIN_W-1:0];
        REG_GAIN_K:     cfg_q.gain_k          <= pwdata[GAIN_W-1:0];
        REG_STEP_RATIO: cfg_q.step_ratio      <= pwdata[GAIN_W-1:0];
        REG_GAIN_G:     cfg_q.gain_g          <= pwdata[GAIN_W-1:0];
        REG_FLUSH_THR:  cfg_q.flush_threshold <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data decode.
  always_comb begin
    unique case (reg_idx)
      REG_SLOPE_GAIN: prdata = DATA_W'(cfg_q.slope_gain);
      REG_GAIN_K:     prdata = DATA_W'(cfg_q.gain_k);
      REG_STEP_RATIO: prdata = DATA_W'(cfg_q.step_ratio);
      REG_GAIN_G:     prdata = DATA_W'(cfg_q.gain_g);
      REG_FLUSH_THR:  prdata = DATA_W'(cfg_q.flush_threshold);
      default:        prdata = '0;
    endcase
  end

  // Front: request queue.
  sse_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sample_i   (sample_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  // Back: window sum and corrector.
  sse_back #(
    .WindowSize (WindowSize)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .window_sum_o (window_sum_o),
    .rate_o       (rate_o),
    .corrected_o  (corrected_o)
  );

endmodule

FILE: rtl/core/sse_checker.sv
// ----------------------------------------------------------------------------
// sse_checker
// Port-level checks of the sliding slope estimator and corrector.
// ----------------------------------------------------------------------------
`include "sliding_slope_estimator_corrector_unit_assert.svh"

module sse_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [23:0] window_sum_o,
  input logic [31:0] rate_o,
  input logic [31:0] corrected_o,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [4:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  logic        out_stall;
  logic [87:0] out_payload;
  logic        wsum_zero;
  logic        gain_wr;
  logic        gain_rd;

  assign out_stall   = out_valid_o && !out_ready_i;
  assign out_payload = {window_sum_o, rate_o, corrected_o};
  assign wsum_zero   = out_valid_o && (window_sum_o == 24'd0);
  assign gain_wr     = psel && penable && pwrite && pready && (paddr == 5'd0);
  assign gain_rd     = psel && !pwrite && (paddr == 5'd0);

  // A waiting result stays offered.
  `SSE_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o, "result dropped while stalled")

  // A stalled result keeps its payload.
  `SSE_ASSERT_NEXT(a_out_stable, out_stall, $stable(out_payload), "result changed while stalled")

  // A zero window sum always scales to a zero rate.
  `SSE_ASSERT_SAME(a_zero_rate, wsum_zero, rate_o == 32'd0, "rate nonzero for zero window sum")

  // The slope gain register reads back what was written, truncated to 24 bits.
  `SSE_ASSERT_NEXT(a_gain_readback, gain_wr, !gain_rd || (prdata == {8'd0, $past(pwdata[23:0])}), "slope gain readback mismatch")

endmodule

bind sliding_slope_estimator_corrector_unit sse_checker u_sse_checker (.*);

FILE: sim/sliding_slope_estimator_corrector_unit_tb.sv
// ----------------------------------------------------------------------------
// Testbench for sliding_slope_estimator_corrector_unit
// Streams angle-code requests through the slope estimator and corrector under
// a series of register settings, from reset values to the extremes. Every
// result is compared, field by field, with a local prediction of the window
// sum, the scaled rate and the corrector output. Both handshakes idle and
// stall at random, with some phases running without gaps.
// ----------------------------------------------------------------------------
module sliding_slope_estimator_corrector_unit_tb
  import sse_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN            = int'(WINDOW_SIZE_DEF);
  localparam int BLOCK_LATENCY  = (WIN - 1) / 2 + 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RESET_CYCLES   = 11;
  localparam int PHASE_COUNT    = 7;
  localparam int PHASE_ITEMS    = 107;
  localparam int REG_COUNT      = int'(REG_FLUSH_THR) + 1;
  localparam int REG_SLOTS      = (2 ** ADDR_W) / 4;
  localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
  localparam logic [THR_W-1:0]  THR_MAX  = '1;
  localparam longint WSUM_MAX = (longint'(1) << (WSUM_W - 1)) - 1;
  localparam longint WSUM_MIN = -WSUM_MAX - 1;
  localparam longint Q_MAX    = (longint'(1) << (Q_W - 1)) - 1;
  localparam longint Q_MIN    = -Q_MAX - 1;

  typedef struct {
    logic signed [WSUM_W-1:0] window_sum;
    logic signed [Q_W-1:0]    rate;
    logic signed [Q_W-1:0]    corrected;
  } slope_estimate_t;

  typedef enum int {SINK_ALWAYS, SINK_CHOPPY, SINK_LONG} sink_mode_e;
  typedef enum int {ANGLE_NOISE, ANGLE_RAMP, ANGLE_EXTREME, ANGLE_STEADY} angle_mode_e;

  // Tracks the delay line, the integrator and the registers, and holds the
  // estimates still owed by the block in request order.
  class slope_estimate_board;
    logic signed [SAMPLE_W-1:0] angle_line[WIN];
    longint integ_q16;
    longint slope_gain, gain_k, step_ratio, gain_g, flush_thr;
    slope_estimate_t pending_estimates[$];
    int failures, compared, noted, rate_sats, corr_sats, flushes;

    function new();
      foreach (angle_line[i]) angle_line[i] = '0;
      integ_q16  = 0;
      slope_gain = SLOPE_GAIN_RST;
      gain_k     = GAIN_K_RST;
      step_ratio = STEP_RATIO_RST;
      gain_g     = GAIN_G_RST;
      flush_thr  = FLUSH_THR_RST;
      failures   = 0;
      compared   = 0;
      noted      = 0;
      rate_sats  = 0;
      corr_sats  = 0;
      flushes    = 0;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Difference of two angle codes, wrapped to 16 bits as the codes wrap.
    function longint wrap_diff(longint a, longint b);
      longint t;
      logic signed [SAMPLE_W-1:0] d;
      t = a - b;
      d = t[SAMPLE_W-1:0];
      return d;
    endfunction

    // Q32.32 product to Q16.16, nearest with ties upwards.
    function longint round_q16(longint p);
      return (p + 64'sd32768) >>> 16;
    endfunction

    function void log_failure(string msg);
      if (failures < 10) $display("%s", msg);
      failures++;
    endfunction

    // Bits above a register's width are dropped; unused slots do nothing.
    function void set_register(int idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_SLOPE_GAIN: slope_gain = data[GAIN_W-1:0];
        REG_GAIN_K:     gain_k     = data[GAIN_W-1:0];
        REG_STEP_RATIO: step_ratio = data[GAIN_W-1:0];
        REG_GAIN_G:     gain_g     = data[GAIN_W-1:0];
        REG_FLUSH_THR:  flush_thr  = data[THR_W-1:0];
        default: ;
      endcase
    endfunction

    // Works out the estimate that an accepted sample must produce.
    function void note_sample(logic signed [SAMPLE_W-1:0] sample);
      longint s, raw, rate, w, mag, e, corr;
      int k;
      slope_estimate_t est;
      s = wrap_diff(sample, angle_line[WIN-1]) * WIN;
      for (k = 1; k <= (WIN - 1) / 2; k++)
        s += wrap_diff(angle_line[k-1], angle_line[WIN-k-1]) * (WIN - 2 * k);
      for (k = WIN - 1; k > 0; k--) angle_line[k] = angle_line[k-1];
      angle_line[0] = sample;

      raw  = s * slope_gain;
      rate = clamp(raw, Q_MIN, Q_MAX);
      if (rate != raw) rate_sats++;

      // The integrator is flushed before the corrector runs.
      w   = integ_q16;
      mag = (w < 0) ? -w : w;
      if (mag < flush_thr) begin
        if (w != 0) flushes++;
        w = 0;
      end
      e    = clamp(round_q16(rate * gain_k) - w, Q_MIN, Q_MAX);
      w    = clamp(round_q16(e * step_ratio) + w, Q_MIN, Q_MAX);
      raw  = round_q16(e * gain_g) + w;
      corr = clamp(raw, Q_MIN, Q_MAX);
      if (corr != raw) corr_sats++;
      integ_q16 = w;

      s = clamp(s, WSUM_MIN, WSUM_MAX);
      est.window_sum = s[WSUM_W-1:0];
      est.rate       = rate[Q_W-1:0];
      est.corrected  = corr[Q_W-1:0];
      pending_estimates.push_back(est);
      noted++;
    endfunction

    function void check_result(logic signed [WSUM_W-1:0] ws, logic signed [Q_W-1:0] rate,
                               logic signed [Q_W-1:0] corr);
      slope_estimate_t est;
      if (pending_estimates.size() == 0) begin
        log_failure($sformatf("Result with no request outstanding: sum %0d rate %0d corr %0d",
                              ws, rate, corr));
        return;
      end
      est = pending_estimates.pop_front();
      if (est.window_sum !== ws || est.rate !== rate || est.corrected !== corr)
        log_failure($sformatf({"Mismatch on result %0d: sum exp %0d got %0d, ",
                               "rate exp %0d got %0d, corr exp %0d got %0d"},
                              compared, est.window_sum, ws, est.rate, rate,
                              est.corrected, corr));
      compared++;
    endfunction

    function int waiting();
      return pending_estimates.size();
    endfunction

    function void close_out();
      if (pending_estimates.size() != 0)
        log_failure($sformatf("%0d estimates never arrived", pending_estimates.size()));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [SAMPLE_W-1:0] sample_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [WSUM_W-1:0] window_sum_o;
  logic signed [Q_W-1:0] rate_o;
  logic signed [Q_W-1:0] corrected_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  slope_estimate_board board;
  sink_mode_e sink_mode = SINK_CHOPPY;
  int sink_hold = 0;
  int idle_cycles = 0;
  int settings_applied = 0;
  logic signed [SAMPLE_W-1:0] ramp_angle = '0;
  logic signed [SAMPLE_W-1:0] ramp_step = 16'sd100;
  logic signed [SAMPLE_W-1:0] opening_samples[$];

  sliding_slope_estimator_corrector_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .window_sum_o (window_sum_o),
    .rate_o       (rate_o),
    .corrected_o  (corrected_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #4 clk_i = ~clk_i;

  // Result side: ready follows its own pattern of stalls.
  always @(posedge clk_i) begin
    if (sink_mode == SINK_ALWAYS) begin
      out_ready_i <= 1'b1;
      sink_hold = 0;
    end else if (sink_hold > 0) begin
      sink_hold--;
    end else begin
      out_ready_i <= !out_ready_i;
      if (out_ready_i) begin
        sink_hold = (sink_mode == SINK_LONG) ? $urandom_range(5, 60) : $urandom_range(0, 3);
      end else begin
        sink_hold = $urandom_range(0, 8);
      end
    end
  end

  // Every accepted result is checked against the oldest estimate.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_result(window_sum_o, rate_o, corrected_o);
  end

  // Ends the run if nothing at all is accepted for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // One register write: setup cycle, then access cycle, then a quiet cycle.
  task automatic write_register(input int idx, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * 4);
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_register(idx, data);
    @(posedge clk_i);
  endtask

  // Random junk above the register width, which the block must ignore.
  function automatic logic [DATA_W-1:0] pad_noise(logic [DATA_W-1:0] v, int w);
    logic [DATA_W-1:0] m;
    m = (DATA_W'(1) << w) - 1;
    return ($urandom & ~m) | (v & m);
  endfunction

  task automatic apply_settings(input logic [GAIN_W-1:0] sg, input logic [GAIN_W-1:0] gk,
                                input logic [GAIN_W-1:0] sr, input logic [GAIN_W-1:0] gg,
                                input logic [THR_W-1:0] thr);
    write_register(REG_SLOPE_GAIN, pad_noise(DATA_W'(sg), GAIN_W));
    write_register(REG_GAIN_K, pad_noise(DATA_W'(gk), GAIN_W));
    write_register(REG_STEP_RATIO, pad_noise(DATA_W'(sr), GAIN_W));
    write_register(REG_GAIN_G, pad_noise(DATA_W'(gg), GAIN_W));
    write_register(REG_FLUSH_THR, pad_noise(DATA_W'(thr), THR_W));
    // A write to an unused slot must leave everything as it was.
    write_register($urandom_range(REG_COUNT, REG_SLOTS - 1), $urandom);
    settings_applied++;
  endtask

  // Register settings of each phase; phase 0 keeps the reset values.
  task automatic load_phase_settings(input int p);
    case (p)
      1: apply_settings(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, THR_MAX);
      2: apply_settings('0, '0, '0, '0, '0);
      3: apply_settings(GAIN_W'($urandom_range(1000, 70000)), GAIN_K_RST,
                        GAIN_W'($urandom_range(0, 65536)),
                        GAIN_W'($urandom_range(0, 1 << 20)),
                        THR_W'($urandom_range(0, THR_MAX)));
      4: apply_settings(GAIN_W'($urandom_range(0, GAIN_MAX)),
                        GAIN_W'($urandom_range(0, GAIN_MAX)),
                        GAIN_W'($urandom_range(0, GAIN_MAX)),
                        GAIN_W'($urandom_range(0, GAIN_MAX)),
                        THR_W'($urandom_range(0, THR_MAX)));
      5: apply_settings(SLOPE_GAIN_RST, GAIN_K_RST, STEP_RATIO_RST, GAIN_G_RST, THR_MAX);
      default: apply_settings(GAIN_W'($urandom_range(0, 300000)), GAIN_MAX, GAIN_MAX,
                              GAIN_W'($urandom_range(0, GAIN_MAX)), '0);
    endcase
  endtask

  // Drive one request and wait until it is accepted.
  task automatic send_angle(input logic signed [SAMPLE_W-1:0] x);
    in_valid_i <= 1'b1;
    sample_i   <= x;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_sample(x);
  endtask

  // Lower valid and hold off until every estimate has come back.
  task automatic hold_off_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.waiting() != 0);
  endtask

  function automatic angle_mode_e pick_angle_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return ANGLE_RAMP;
    if (r < 60) return ANGLE_STEADY;
    if (r < 85) return ANGLE_NOISE;
    return ANGLE_EXTREME;
  endfunction

  // Next angle code; ramps wrap around the code circle like a turning shaft.
  function automatic logic signed [SAMPLE_W-1:0] next_angle(angle_mode_e m);
    logic signed [SAMPLE_W-1:0] jitter;
    jitter = SAMPLE_W'($urandom_range(0, 8)) - 16'sd4;
    case (m)
      ANGLE_RAMP: begin
        ramp_angle = ramp_angle + ramp_step + jitter;
        return ramp_angle;
      end
      ANGLE_STEADY: return ramp_angle + jitter;
      ANGLE_EXTREME: begin
        case ($urandom_range(0, 4))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return 16'sh0000;
          3: return 16'shFFFF;
          default: return 16'sh0001;
        endcase
      end
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Bursts of requests with random gaps, or back to back when idle_free is set.
  task automatic send_bursts(input int count, input bit idle_free);
    int sent, blen, i, r;
    angle_mode_e m;
    sent = 0;
    while (sent < count) begin
      blen = $urandom_range(1, 20);
      m    = pick_angle_mode();
      if (m == ANGLE_RAMP && $urandom_range(0, 9) < 3) begin
        if ($urandom_range(0, 4) == 0) ramp_step = SAMPLE_W'($urandom);
        else ramp_step = SAMPLE_W'($urandom_range(0, 6000)) - 16'sd3000;
      end
      for (i = 0; i < blen && sent < count; i++) begin
        send_angle(next_angle(m));
        sent++;
      end
      if (!idle_free && sent < count) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          hold_off_until_drained();
        end else if (r >= 30) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 40)) @(posedge clk_i);
        end
      end
    end
  endtask

  initial begin
    int p;
    bit idle_free;
    board = new();
    opening_samples = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh0000,
                        16'shFFFF, 16'sh0001, 16'shFFFF, 16'sh4000, 16'shC000, 16'sh7FFF,
                        16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh0000, 16'sh7F00, 16'sh8100,
                        16'sh0064, 16'sh00C8};
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (p = 0; p < PHASE_COUNT; p++) begin
      if (p > 0) load_phase_settings(p);
      idle_free = (p % 3 == 2);
      sink_mode <= idle_free ? SINK_ALWAYS : ((p % 2 == 1) ? SINK_LONG : SINK_CHOPPY);
      if (p == 0) begin
        foreach (opening_samples[i]) send_angle(opening_samples[i]);
      end
      send_bursts(PHASE_ITEMS, idle_free);
      hold_off_until_drained();
      repeat (BLOCK_LATENCY) @(posedge clk_i);
    end

    board.close_out();
    $display("Summary: %0d samples under %0d register settings, %0d results compared.",
             board.noted, settings_applied + 1, board.compared);
    $display({"Rate saturated %0d times, corrector output %0d times, ",
              "integrator flushed %0d times."},
             board.rate_sats, board.corr_sats, board.flushes);
    if (board.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d failures in total", board.failures);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
